// ===== rtl/core/sgcm_pkg.sv =====
// Shared types and constants for the slewed gain crossfade mixer.
// No dependencies; imported by every other file of the block.
package sgcm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LANE_RELATION   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LAW        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW_ONE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH_ONE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW_TWO  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH_TWO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_STEP       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_STEP       = 3'd7;

  localparam logic [1:0] REL_INDEPENDENT = 2'd0;
  localparam logic [1:0] REL_COPY        = 2'd1;
  localparam logic [1:0] REL_INVERT      = 2'd2;

  localparam logic       LAW_LINEAR  = 1'b0;
  localparam logic       LAW_SQUARED = 1'b1;

  localparam logic [7:0] WINDOW_LOW_RESET  = 8'd0;
  localparam logic [7:0] WINDOW_HIGH_RESET = 8'd255;
  localparam logic [5:0] STEP_RESET        = 6'd43;

  localparam logic [3:0]         WINDOW_LOW_NIBBLE = 4'h0;
  localparam logic [3:0]         WINDOW_HIGH_NIBBLE = 4'hf;
  localparam logic signed [19:0] MID_SCALE = 20'sd2048;
  localparam logic [11:0]        FULL_SCALE = 12'd4095;
  localparam logic signed [13:0] SAMPLE_MAX = 14'sd2047;
  localparam logic signed [13:0] SAMPLE_MIN = -14'sd2048;

  typedef struct packed {
    logic [1:0] lane_relation;
    logic       gain_law;
    logic [7:0] window_low_one;
    logic [7:0] window_high_one;
    logic [7:0] window_low_two;
    logic [7:0] window_high_two;
    logic [5:0] rise_step;
    logic [5:0] fall_step;
  } cfg_t;

  typedef struct packed {
    logic               layer_active;
    logic [11:0]        target_one;
    logic [11:0]        target_two;
    logic [11:0]        depth_one;
    logic [11:0]        depth_two;
    logic signed [11:0] audio_in_one;
    logic signed [11:0] audio_in_two;
    logic signed [11:0] cv_in_one;
    logic signed [11:0] cv_in_two;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] audio_out_one;
    logic signed [11:0] audio_out_two;
    logic signed [11:0] cv_out_one;
    logic signed [11:0] cv_out_two;
    logic               cv_driven;
    logic [11:0]        level_one;
    logic [11:0]        level_two;
  } out_item_t;

endpackage

// ===== rtl/core/sgcm_if.sv =====
// Valid/ready stream interfaces for input items and result items.
// Depends on sgcm_pkg for the item types.
interface sgcm_in_if import sgcm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sgcm_out_if import sgcm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sgcm_regs.sv =====
// Configuration register file of the mixer, written through a plain write port.
// Depends on sgcm_pkg.
module sgcm_regs import sgcm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lane_relation   <= REL_INDEPENDENT;
      cfg.gain_law        <= LAW_LINEAR;
      cfg.window_low_one  <= WINDOW_LOW_RESET;
      cfg.window_high_one <= WINDOW_HIGH_RESET;
      cfg.window_low_two  <= WINDOW_LOW_RESET;
      cfg.window_high_two <= WINDOW_HIGH_RESET;
      cfg.rise_step       <= STEP_RESET;
      cfg.fall_step       <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LANE_RELATION:   cfg.lane_relation   <= cfg_data[1:0];
        REG_GAIN_LAW:        cfg.gain_law        <= cfg_data[0];
        REG_WINDOW_LOW_ONE:  cfg.window_low_one  <= cfg_data;
        REG_WINDOW_HIGH_ONE: cfg.window_high_one <= cfg_data;
        REG_WINDOW_LOW_TWO:  cfg.window_low_two  <= cfg_data;
        REG_WINDOW_HIGH_TWO: cfg.window_high_two <= cfg_data;
        REG_RISE_STEP:       cfg.rise_step       <= cfg_data[5:0];
        REG_FALL_STEP:       cfg.fall_step       <= cfg_data[5:0];
      endcase
    end
  end

endmodule

// ===== rtl/core/sgcm_front.sv =====
// Front end: accepts input items and resolves the lane two target relation.
// Depends on sgcm_pkg and sgcm_if.
module sgcm_front import sgcm_pkg::*; (
  input  logic        [1:0] lane_relation,
  sgcm_in_if.sink           sample_in,
  sgcm_in_if.source         job_out
);

  in_item_t job;

  always_comb begin
    job = sample_in.data;
    priority case (lane_relation)
      REL_COPY:   job.target_two = sample_in.data.target_one;
      REL_INVERT: job.target_two = FULL_SCALE - sample_in.data.target_one;
      default:    job.target_two = sample_in.data.target_two;
    endcase
  end

  assign job_out.valid   = sample_in.valid;
  assign job_out.data    = job;
  assign sample_in.ready = job_out.ready;

endmodule

// ===== rtl/core/sgcm_queue.sv =====
// Short item queue between front and back ends.
// Depends on sgcm_pkg and sgcm_if.
module sgcm_queue import sgcm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  sgcm_in_if.sink   push,
  sgcm_in_if.source pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  in_item_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push.ready = (count != CNT_W'(DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.data   = mem[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sgcm_back.sv =====
// Back end: sequencer around one shared multiplier for shaping and crossfade, with the slew
// update and the result register. Depends on sgcm_pkg and sgcm_if.
module sgcm_back import sgcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  sgcm_in_if.sink    job_in,
  sgcm_out_if.source mix_out
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_DEPTH,
    ST_SQUARE,
    ST_SLEW,
    ST_MIX_OWN,
    ST_MIX_OTHER,
    ST_EMIT
  } state_t;

  state_t             state;
  in_item_t           job;
  logic               lane_sel;
  logic [1:0]         mix_sel;
  logic signed [13:0] lane_val;
  logic [11:0]        shaped;
  logic [11:0]        level_one;
  logic [11:0]        level_two;
  logic signed [25:0] acc;
  logic signed [11:0] res [4];
  logic               out_valid;
  out_item_t          out_data;

  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [31:0] prod;
  logic signed [19:0] prod_sh;

  logic [11:0]        lane_target;
  logic [11:0]        lane_depth;
  logic [11:0]        level_cur;
  logic [7:0]         wlo;
  logic [7:0]         whi;
  logic signed [12:0] lo13;
  logic signed [12:0] hi13;
  logic signed [12:0] span;
  logic signed [14:0] lane_dev;
  logic signed [15:0] map_sum;
  logic signed [19:0] depth_sum;
  logic [11:0]        depth_clamped;
  logic signed [13:0] lvl14;
  logic signed [13:0] tgt14;
  logic signed [13:0] up14;
  logic signed [13:0] dn14;
  logic signed [13:0] slew14;
  logic [11:0]        slew_next;

  logic [11:0]        mix_gain;
  logic signed [11:0] mix_own;
  logic signed [11:0] mix_other;
  logic signed [25:0] mix_total;
  logic signed [13:0] mix_sh;
  logic signed [11:0] mix_sat;

  logic               out_free;
  logic               emit_fire;

  assign lane_target = lane_sel ? job.target_two : job.target_one;
  assign lane_depth  = lane_sel ? job.depth_two : job.depth_one;
  assign level_cur   = lane_sel ? level_two : level_one;
  assign wlo         = lane_sel ? cfg.window_low_two : cfg.window_low_one;
  assign whi         = lane_sel ? cfg.window_high_two : cfg.window_high_one;
  assign lo13        = {1'b0, wlo, WINDOW_LOW_NIBBLE};
  assign hi13        = {1'b0, whi, WINDOW_HIGH_NIBBLE};
  assign span        = hi13 - lo13;
  assign lane_dev    = {lane_val[13], lane_val} - 15'sd2048;

  assign mix_gain  = mix_sel[0] ? level_two : level_one;
  assign mix_own   = mix_sel[1] ? (mix_sel[0] ? job.cv_in_two : job.cv_in_one)
                                : (mix_sel[0] ? job.audio_in_two : job.audio_in_one);
  assign mix_other = mix_sel[1] ? (mix_sel[0] ? job.cv_in_one : job.cv_in_two)
                                : (mix_sel[0] ? job.audio_in_one : job.audio_in_two);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MAP: begin
        mul_a = {4'b0, lane_target};
        mul_b = {{3{span[12]}}, span};
      end
      ST_DEPTH: begin
        mul_a = {lane_dev[14], lane_dev};
        mul_b = {4'b0, lane_depth};
      end
      ST_SQUARE: begin
        mul_a = {4'b0, shaped};
        mul_b = {4'b0, shaped};
      end
      ST_MIX_OWN: begin
        mul_a = {{4{mix_own[11]}}, mix_own};
        mul_b = {4'b0, mix_gain};
      end
      ST_MIX_OTHER: begin
        mul_a = {{4{mix_other[11]}}, mix_other};
        mul_b = {4'b0, ~mix_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod[31:12];

  assign map_sum   = {{3{lo13[12]}}, lo13} + prod_sh[15:0];
  assign depth_sum = MID_SCALE + prod_sh;

  always_comb begin
    priority if (depth_sum < 20'sd0) begin
      depth_clamped = '0;
    end else if (depth_sum > 20'sd4095) begin
      depth_clamped = FULL_SCALE;
    end else begin
      depth_clamped = depth_sum[11:0];
    end
  end

  assign lvl14 = {2'b0, level_cur};
  assign tgt14 = {2'b0, shaped};
  assign up14  = lvl14 + {8'b0, cfg.rise_step};
  assign dn14  = lvl14 - {8'b0, cfg.fall_step};

  always_comb begin
    priority if (lvl14 < tgt14) begin
      slew14 = (up14 > tgt14) ? tgt14 : up14;
    end else if (lvl14 > tgt14) begin
      slew14 = (dn14 < tgt14) ? tgt14 : dn14;
    end else begin
      slew14 = lvl14;
    end
  end
  assign slew_next = slew14[11:0];

  assign mix_total = acc + prod[25:0];
  assign mix_sh    = mix_total[25:12];

  always_comb begin
    priority if (mix_sh > SAMPLE_MAX) begin
      mix_sat = SAMPLE_MAX[11:0];
    end else if (mix_sh < SAMPLE_MIN) begin
      mix_sat = SAMPLE_MIN[11:0];
    end else begin
      mix_sat = mix_sh[11:0];
    end
  end

  assign out_free      = !out_valid || mix_out.ready;
  assign emit_fire     = (state == ST_EMIT) && out_free;
  assign job_in.ready  = (state == ST_IDLE);
  assign mix_out.valid = out_valid;
  assign mix_out.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      level_one <= '0;
      level_two <= '0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (mix_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_in.valid) begin
            job      <= job_in.data;
            lane_sel <= 1'b0;
            mix_sel  <= '0;
            state    <= job_in.data.layer_active ? ST_MAP : ST_EMIT;
          end
        end
        ST_MAP: begin
          lane_val <= map_sum[13:0];
          state    <= ST_DEPTH;
        end
        ST_DEPTH: begin
          shaped <= depth_clamped;
          state  <= (cfg.gain_law == LAW_SQUARED) ? ST_SQUARE : ST_SLEW;
        end
        ST_SQUARE: begin
          shaped <= prod[23:12];
          state  <= ST_SLEW;
        end
        ST_SLEW: begin
          if (lane_sel) begin
            level_two <= slew_next;
            state     <= ST_MIX_OWN;
          end else begin
            level_one <= slew_next;
            lane_sel  <= 1'b1;
            state     <= ST_MAP;
          end
        end
        ST_MIX_OWN: begin
          acc   <= prod[25:0];
          state <= ST_MIX_OTHER;
        end
        ST_MIX_OTHER: begin
          res[mix_sel] <= mix_sat;
          mix_sel      <= mix_sel + 1'b1;
          state        <= (mix_sel == 2'd3) ? ST_EMIT : ST_MIX_OWN;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (job.layer_active) begin
              out_data.audio_out_one <= res[0];
              out_data.audio_out_two <= res[1];
              out_data.cv_out_one    <= res[2];
              out_data.cv_out_two    <= res[3];
            end else begin
              out_data.audio_out_one <= job.audio_in_one;
              out_data.audio_out_two <= job.audio_in_two;
              out_data.cv_out_one    <= '0;
              out_data.cv_out_two    <= '0;
            end
            out_data.cv_driven <= job.layer_active;
            out_data.level_one <= level_one;
            out_data.level_two <= level_two;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/slewed_gain_crossfade_mixer.sv =====
// Top level of the slewed gain crossfade mixer: registers, front end, queue, back end.
// Depends on sgcm_pkg, sgcm_if, sgcm_regs, sgcm_front, sgcm_queue and sgcm_back.
//
// For an active item the back end uses one shared 16x16 multiplier for the window
// map, the depth shaping and the optional squaring (squared gain law only) of each
// lane, then for the two products of each of the four crossfades; the slew update
// of each lane follows its shaping as a separate step. A bypass item goes from
// idle straight to emit. The input queue holds QUEUE_DEPTH items, so the source
// is stalled only when it runs ahead of the back end, and the result register
// lets the back end start the next item while a result waits to be taken. The
// user must write configuration only while idle; the block does not enforce it.
module slewed_gain_crossfade_mixer import sgcm_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sgcm_in_if.sink                sample_in,
  sgcm_out_if.source             mix_out
);

  cfg_t      cfg;
  sgcm_in_if front_to_queue ();
  sgcm_in_if queue_to_back ();

  sgcm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgcm_front u_front (
    .lane_relation (cfg.lane_relation),
    .sample_in     (sample_in),
    .job_out       (front_to_queue)
  );

  sgcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_to_queue),
    .pop  (queue_to_back)
  );

  sgcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .job_in  (queue_to_back),
    .mix_out (mix_out)
  );

endmodule
